[rtl/c6502eu_pkg.sv]
// package for the 6502 execute unit: decoded operation codes and queue entry type
// no dependencies

package c6502eu_pkg;

  typedef enum logic [5:0] {
    OP_ILL, OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_STA, OP_LDA, OP_CMP, OP_SBC,
    OP_ASLA, OP_ROLA, OP_LSRA, OP_RORA, OP_ASL, OP_ROL, OP_LSR, OP_ROR,
    OP_DEC, OP_INC, OP_STX, OP_STY, OP_LDX, OP_LDY, OP_CPX, OP_CPY, OP_BIT,
    OP_TXA, OP_TYA, OP_TAX, OP_TAY, OP_TSX, OP_TXS, OP_INX, OP_DEX, OP_INY,
    OP_DEY, OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD, OP_SED, OP_NOP,
    OP_LAX, OP_SAX, OP_SLO, OP_RLA, OP_SRE, OP_RRA, OP_DCP, OP_ISB, OP_ANC,
    OP_ALR, OP_ARR, OP_ATX, OP_AXS
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] operand;
  } uop_t;

  localparam logic [7:0] SP_RESET = 8'hFD;
  localparam logic [7:0] P_RESET  = 8'h24;

endpackage

[rtl/c6502eu_decode.sv]
// front end: classifies the opcode byte into a decoded operation
// depends on c6502eu_pkg

module c6502eu_decode import c6502eu_pkg::*; (
  input  logic [7:0] func,
  input  logic [7:0] operand,
  output uop_t       uop
);

  op_t op;

  always_comb begin
    case (func)
      8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: op = OP_ORA;
      8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: op = OP_AND;
      8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: op = OP_EOR;
      8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: op = OP_ADC;
      8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D: op = OP_STA;
      8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: op = OP_LDA;
      8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: op = OP_CMP;
      8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD: op = OP_SBC;
      8'h0A: op = OP_ASLA;
      8'h2A: op = OP_ROLA;
      8'h4A: op = OP_LSRA;
      8'h6A: op = OP_RORA;
      8'h06, 8'h0E, 8'h16, 8'h1E: op = OP_ASL;
      8'h26, 8'h2E, 8'h36, 8'h3E: op = OP_ROL;
      8'h46, 8'h4E, 8'h56, 8'h5E: op = OP_LSR;
      8'h66, 8'h6E, 8'h76, 8'h7E: op = OP_ROR;
      8'hC6, 8'hCE, 8'hD6, 8'hDE: op = OP_DEC;
      8'hE6, 8'hEE, 8'hF6, 8'hFE: op = OP_INC;
      8'h86, 8'h8E, 8'h96: op = OP_STX;
      8'h84, 8'h8C, 8'h94: op = OP_STY;
      8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: op = OP_LDX;
      8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: op = OP_LDY;
      8'hE0, 8'hE4, 8'hEC: op = OP_CPX;
      8'hC0, 8'hC4, 8'hCC: op = OP_CPY;
      8'h24, 8'h2C: op = OP_BIT;
      8'h8A: op = OP_TXA;
      8'h98: op = OP_TYA;
      8'hAA: op = OP_TAX;
      8'hA8: op = OP_TAY;
      8'hBA: op = OP_TSX;
      8'h9A: op = OP_TXS;
      8'hE8: op = OP_INX;
      8'hCA: op = OP_DEX;
      8'hC8: op = OP_INY;
      8'h88: op = OP_DEY;
      8'h18: op = OP_CLC;
      8'h38: op = OP_SEC;
      8'h58: op = OP_CLI;
      8'h78: op = OP_SEI;
      8'hB8: op = OP_CLV;
      8'hD8: op = OP_CLD;
      8'hF8: op = OP_SED;
      8'hEA: op = OP_NOP;
      8'hA3, 8'hA7, 8'hAF, 8'hB3, 8'hB7, 8'hBF: op = OP_LAX;
      8'h83, 8'h87, 8'h8F, 8'h97: op = OP_SAX;
      8'h03, 8'h07, 8'h0F, 8'h13, 8'h17, 8'h1B, 8'h1F: op = OP_SLO;
      8'h23, 8'h27, 8'h2F, 8'h33, 8'h37, 8'h3B, 8'h3F: op = OP_RLA;
      8'h43, 8'h47, 8'h4F, 8'h53, 8'h57, 8'h5B, 8'h5F: op = OP_SRE;
      8'h63, 8'h67, 8'h6F, 8'h73, 8'h77, 8'h7B, 8'h7F: op = OP_RRA;
      8'hC3, 8'hC7, 8'hCF, 8'hD3, 8'hD7, 8'hDB, 8'hDF: op = OP_DCP;
      8'hE3, 8'hE7, 8'hEF, 8'hF3, 8'hF7, 8'hFB, 8'hFF: op = OP_ISB;
      8'h0B, 8'h2B: op = OP_ANC;
      8'h4B: op = OP_ALR;
      8'h6B: op = OP_ARR;
      8'hAB: op = OP_ATX;
      8'hCB: op = OP_AXS;
      default: op = OP_ILL;
    endcase
  end

  assign uop.op      = op;
  assign uop.operand = operand;

endmodule

[rtl/c6502eu_fifo.sv]
// two-entry queue between decode and execute
// depends on c6502eu_pkg

module c6502eu_fifo import c6502eu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  uop_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output uop_t out_data
);

  uop_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/c6502eu_exec.sv]
// back end: architectural registers, alu and registered result stage
// depends on c6502eu_pkg

module c6502eu_exec import c6502eu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  uop_t       uop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       write_enable,
  output logic [7:0] write_data,
  output logic [7:0] acc_out,
  output logic [7:0] x_out,
  output logic [7:0] y_out,
  output logic [7:0] status_out,
  output logic [7:0] sp_out,
  output logic       illegal
);

  logic [7:0] a, x, y, sp, p;
  logic [7:0] a_next, x_next, y_next, sp_next, p_next;
  logic       we_next, ill_next;
  logic [7:0] wd_next;
  logic [7:0] m, t, sh, adc_in, cmp_r, cmp_m, nz_v;
  logic [8:0] sum, diff;
  logic       sh_c, do_adc, do_cmp, do_nz;
  logic       fire;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign m        = uop.operand;

  always_comb begin
    a_next = a; x_next = x; y_next = y; sp_next = sp; p_next = p;
    we_next = 1'b0; wd_next = 8'h00; ill_next = 1'b0;
    t = a & m;
    sh = 8'h00; sh_c = 1'b0;
    adc_in = m; do_adc = 1'b0;
    cmp_r = a; cmp_m = m; do_cmp = 1'b0;
    do_nz = 1'b0; nz_v = 8'h00;
    // shifter input selection
    case (uop.op)
      OP_ASLA: begin sh = {a[6:0], 1'b0}; sh_c = a[7]; end
      OP_ROLA: begin sh = {a[6:0], p[0]}; sh_c = a[7]; end
      OP_LSRA: begin sh = {1'b0, a[7:1]}; sh_c = a[0]; end
      OP_RORA: begin sh = {p[0], a[7:1]}; sh_c = a[0]; end
      OP_ASL, OP_SLO: begin sh = {m[6:0], 1'b0}; sh_c = m[7]; end
      OP_ROL, OP_RLA: begin sh = {m[6:0], p[0]}; sh_c = m[7]; end
      OP_LSR, OP_SRE: begin sh = {1'b0, m[7:1]}; sh_c = m[0]; end
      OP_ROR, OP_RRA: begin sh = {p[0], m[7:1]}; sh_c = m[0]; end
      OP_ALR: begin sh = {1'b0, t[7:1]}; sh_c = t[0]; end
      default: ;
    endcase
    case (uop.op)
      OP_ORA: begin a_next = a | m; do_nz = 1'b1; nz_v = a | m; end
      OP_AND: begin a_next = t; do_nz = 1'b1; nz_v = t; end
      OP_EOR: begin a_next = a ^ m; do_nz = 1'b1; nz_v = a ^ m; end
      OP_ADC: do_adc = 1'b1;
      OP_SBC: begin adc_in = ~m; do_adc = 1'b1; end
      OP_STA: begin we_next = 1'b1; wd_next = a; end
      OP_LDA: begin a_next = m; do_nz = 1'b1; nz_v = m; end
      OP_CMP: do_cmp = 1'b1;
      OP_CPX: begin cmp_r = x; do_cmp = 1'b1; end
      OP_CPY: begin cmp_r = y; do_cmp = 1'b1; end
      OP_ASLA, OP_ROLA, OP_LSRA, OP_RORA, OP_ALR: begin
        a_next = sh; p_next[0] = sh_c; do_nz = 1'b1; nz_v = sh;
      end
      OP_ASL, OP_ROL, OP_LSR, OP_ROR: begin
        we_next = 1'b1; wd_next = sh; p_next[0] = sh_c; do_nz = 1'b1; nz_v = sh;
      end
      OP_DEC: begin we_next = 1'b1; wd_next = m - 8'd1; do_nz = 1'b1; nz_v = m - 8'd1; end
      OP_INC: begin we_next = 1'b1; wd_next = m + 8'd1; do_nz = 1'b1; nz_v = m + 8'd1; end
      OP_STX: begin we_next = 1'b1; wd_next = x; end
      OP_STY: begin we_next = 1'b1; wd_next = y; end
      OP_LDX: begin x_next = m; do_nz = 1'b1; nz_v = m; end
      OP_LDY: begin y_next = m; do_nz = 1'b1; nz_v = m; end
      OP_BIT: begin p_next[7:6] = m[7:6]; p_next[1] = (t == 8'h00); end
      OP_TXA: begin a_next = x; do_nz = 1'b1; nz_v = x; end
      OP_TYA: begin a_next = y; do_nz = 1'b1; nz_v = y; end
      OP_TAX: begin x_next = a; do_nz = 1'b1; nz_v = a; end
      OP_TAY: begin y_next = a; do_nz = 1'b1; nz_v = a; end
      OP_TSX: begin x_next = sp; do_nz = 1'b1; nz_v = sp; end
      OP_TXS: sp_next = x;
      OP_INX: begin x_next = x + 8'd1; do_nz = 1'b1; nz_v = x + 8'd1; end
      OP_DEX: begin x_next = x - 8'd1; do_nz = 1'b1; nz_v = x - 8'd1; end
      OP_INY: begin y_next = y + 8'd1; do_nz = 1'b1; nz_v = y + 8'd1; end
      OP_DEY: begin y_next = y - 8'd1; do_nz = 1'b1; nz_v = y - 8'd1; end
      OP_CLC: p_next[0] = 1'b0;
      OP_SEC: p_next[0] = 1'b1;
      OP_CLI: p_next[2] = 1'b0;
      OP_SEI: p_next[2] = 1'b1;
      OP_CLV: p_next[6] = 1'b0;
      OP_CLD: p_next[3] = 1'b0;
      OP_SED: p_next[3] = 1'b1;
      OP_NOP: ;
      OP_LAX: begin a_next = m; x_next = m; do_nz = 1'b1; nz_v = m; end
      OP_SAX: begin we_next = 1'b1; wd_next = a & x; end
      OP_SLO: begin
        we_next = 1'b1; wd_next = sh; p_next[0] = sh_c;
        a_next = a | sh; do_nz = 1'b1; nz_v = a | sh;
      end
      OP_RLA: begin
        we_next = 1'b1; wd_next = sh; p_next[0] = sh_c;
        a_next = a & sh; do_nz = 1'b1; nz_v = a & sh;
      end
      OP_SRE: begin
        we_next = 1'b1; wd_next = sh; p_next[0] = sh_c;
        a_next = a ^ sh; do_nz = 1'b1; nz_v = a ^ sh;
      end
      OP_RRA: begin
        we_next = 1'b1; wd_next = sh; p_next[0] = sh_c; adc_in = sh; do_adc = 1'b1;
      end
      OP_DCP: begin
        we_next = 1'b1; wd_next = m - 8'd1; cmp_m = m - 8'd1; do_cmp = 1'b1;
      end
      OP_ISB: begin
        we_next = 1'b1; wd_next = m + 8'd1; adc_in = ~(m + 8'd1); do_adc = 1'b1;
      end
      OP_ANC: begin a_next = t; p_next[0] = t[7]; do_nz = 1'b1; nz_v = t; end
      OP_ARR: begin
        a_next = {p[0], t[7:1]};
        p_next[0] = t[7];
        p_next[6] = t[7] ^ t[6];
        do_nz = 1'b1; nz_v = {p[0], t[7:1]};
      end
      OP_ATX: begin a_next = t; x_next = t; do_nz = 1'b1; nz_v = t; end
      OP_AXS: begin
        cmp_r = a & x; do_cmp = 1'b1; x_next = (a & x) - m;
      end
      default: ill_next = 1'b1;
    endcase
    // adder, carry in from the flag after any shift (rra uses the new carry)
    sum = {1'b0, a} + {1'b0, adc_in} + {8'h00, p_next[0]};
    if (do_adc) begin
      a_next = sum[7:0];
      p_next[6] = ~(a[7] ^ adc_in[7]) & (a[7] ^ sum[7]);
      p_next[0] = sum[8];
      do_nz = 1'b1; nz_v = sum[7:0];
    end
    diff = {1'b0, cmp_r} - {1'b0, cmp_m};
    if (do_cmp) begin
      p_next[0] = ~diff[8];
      do_nz = 1'b1; nz_v = diff[7:0];
    end
    if (do_nz) begin
      p_next[1] = (nz_v == 8'h00);
      p_next[7] = nz_v[7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a <= 8'h00; x <= 8'h00; y <= 8'h00; sp <= SP_RESET; p <= P_RESET;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        a <= a_next; x <= x_next; y <= y_next; sp <= sp_next; p <= p_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      write_enable <= we_next;
      write_data   <= wd_next;
      illegal      <= ill_next;
    end
  end

  assign acc_out    = a;
  assign x_out      = x;
  assign y_out      = y;
  assign status_out = p;
  assign sp_out     = sp;

endmodule

[rtl/cpu6502_execute_unit_core.sv]
// 6502 execute unit: decode front end, two-beat queue, execute back end
// path: an input beat is registered in the queue, then in the result register
// throughput: one instruction per cycle, both sides stall independently
// rate is set by the combinational alu and register file update in the back end
// reset: a = x = y = 0, sp = 0xfd, p = 0x24, queue empty, no result pending

module cpu6502_execute_unit_core import c6502eu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] func,
  input  logic [7:0] operand,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       write_enable,
  output logic [7:0] write_data,
  output logic [7:0] acc_out,
  output logic [7:0] x_out,
  output logic [7:0] y_out,
  output logic [7:0] status_out,
  output logic [7:0] sp_out,
  output logic       illegal
);

  // decoded beat from the front end
  uop_t dec_uop;
  // queue output toward the back end
  uop_t q_uop;
  logic q_valid;
  logic q_ready;

  c6502eu_decode u_decode (
    .func    (func),
    .operand (operand),
    .uop     (dec_uop)
  );

  // short queue decouples accept side from the execute stall
  c6502eu_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (dec_uop),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_uop)
  );

  // back end updates architectural state as it loads the result register
  c6502eu_exec u_exec (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .uop          (q_uop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_enable (write_enable),
    .write_data   (write_data),
    .acc_out      (acc_out),
    .x_out        (x_out),
    .y_out        (y_out),
    .status_out   (status_out),
    .sp_out       (sp_out),
    .illegal      (illegal)
  );

  // an illegal opcode never writes memory
  a_ill_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && illegal |-> !write_enable)
    else $error("illegal opcode with write");

  // a stalled result keeps its register values
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(acc_out) && $stable(status_out))
    else $error("stalled result changed");

  // status bit 5 stays set from reset on
  a_bit5: assert property (@(posedge clk) disable iff (rst)
    status_out[5])
    else $error("status bit 5 lost");

endmodule

[bench/tb_cpu6502_execute_unit_core.sv]
// testbench for the 6502 execute unit: random and directed opcode/operand beats
// depends on rtl/c6502eu_pkg.sv and rtl/cpu6502_execute_unit_core.sv
`timescale 1ns / 100ps

module tb_cpu6502_execute_unit_core;
  import c6502eu_pkg::*;

  typedef struct packed {
    logic       we;
    logic [7:0] wd;
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
    logic [7:0] sp;
    logic       ill;
  } exec_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] func = 8'h00;
  logic [7:0] operand = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       write_enable;
  logic [7:0] write_data, acc_out, x_out, y_out, status_out, sp_out;
  logic       illegal;

  cpu6502_execute_unit_core u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .operand(operand), .out_valid(out_valid), .out_ready(out_ready),
    .write_enable(write_enable), .write_data(write_data), .acc_out(acc_out),
    .x_out(x_out), .y_out(y_out), .status_out(status_out), .sp_out(sp_out),
    .illegal(illegal)
  );

  always #5 clk = ~clk;

  // shadow architectural registers
  logic [7:0] sh_a, sh_x, sh_y, sh_sp, sh_p;

  logic [15:0] pending_instr[$];  // {func, operand} waiting to be driven
  exec_res_t   expected_res[$];
  int          errors = 0;
  bit          calm = 1'b0;       // long stretch with no idling
  bit          hold_in = 1'b0;    // sender pause until drained

  function automatic void flag_nz(logic [7:0] v);
    sh_p[1] = (v == 8'h00);
    sh_p[7] = v[7];
  endfunction

  function automatic void alu_adc(logic [7:0] m);
    logic [8:0] s;
    s = {1'b0, sh_a} + {1'b0, m} + {8'h00, sh_p[0]};
    sh_p[6] = (~(sh_a[7] ^ m[7])) & (sh_a[7] ^ s[7]);
    sh_p[0] = s[8];
    sh_a = s[7:0];
    flag_nz(sh_a);
  endfunction

  function automatic void alu_cmp(logic [7:0] r, logic [7:0] m);
    sh_p[0] = (r >= m);
    flag_nz(r - m);
  endfunction

  function automatic logic [7:0] sh_asl(logic [7:0] m);
    sh_p[0] = m[7];
    return {m[6:0], 1'b0};
  endfunction

  function automatic logic [7:0] sh_lsr(logic [7:0] m);
    sh_p[0] = m[0];
    return {1'b0, m[7:1]};
  endfunction

  function automatic logic [7:0] sh_rol(logic [7:0] m);
    logic [7:0] r;
    r = {m[6:0], sh_p[0]};
    sh_p[0] = m[7];
    return r;
  endfunction

  function automatic logic [7:0] sh_ror(logic [7:0] m);
    logic [7:0] r;
    r = {sh_p[0], m[7:1]};
    sh_p[0] = m[0];
    return r;
  endfunction

  // execute one instruction on the shadow registers
  function automatic exec_res_t execute_instr(logic [7:0] op, logic [7:0] m);
    exec_res_t r;
    logic [7:0] t;
    r.we = 1'b0; r.wd = 8'h00; r.ill = 1'b0;
    case (op)
      8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: begin
        sh_a = sh_a | m; flag_nz(sh_a);
      end
      8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: begin
        sh_a = sh_a & m; flag_nz(sh_a);
      end
      8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: begin
        sh_a = sh_a ^ m; flag_nz(sh_a);
      end
      8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: alu_adc(m);
      8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D: begin
        r.we = 1'b1; r.wd = sh_a;
      end
      8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: begin
        sh_a = m; flag_nz(m);
      end
      8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: alu_cmp(sh_a, m);
      8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD: alu_adc(~m);
      8'h0A: begin sh_a = sh_asl(sh_a); flag_nz(sh_a); end
      8'h2A: begin sh_a = sh_rol(sh_a); flag_nz(sh_a); end
      8'h4A: begin sh_a = sh_lsr(sh_a); flag_nz(sh_a); end
      8'h6A: begin sh_a = sh_ror(sh_a); flag_nz(sh_a); end
      8'h06, 8'h0E, 8'h16, 8'h1E: begin r.wd = sh_asl(m); r.we = 1'b1; flag_nz(r.wd); end
      8'h26, 8'h2E, 8'h36, 8'h3E: begin r.wd = sh_rol(m); r.we = 1'b1; flag_nz(r.wd); end
      8'h46, 8'h4E, 8'h56, 8'h5E: begin r.wd = sh_lsr(m); r.we = 1'b1; flag_nz(r.wd); end
      8'h66, 8'h6E, 8'h76, 8'h7E: begin r.wd = sh_ror(m); r.we = 1'b1; flag_nz(r.wd); end
      8'hC6, 8'hCE, 8'hD6, 8'hDE: begin r.wd = m - 8'd1; r.we = 1'b1; flag_nz(r.wd); end
      8'hE6, 8'hEE, 8'hF6, 8'hFE: begin r.wd = m + 8'd1; r.we = 1'b1; flag_nz(r.wd); end
      8'h86, 8'h8E, 8'h96: begin r.we = 1'b1; r.wd = sh_x; end
      8'h84, 8'h8C, 8'h94: begin r.we = 1'b1; r.wd = sh_y; end
      8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: begin sh_x = m; flag_nz(m); end
      8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: begin sh_y = m; flag_nz(m); end
      8'hE0, 8'hE4, 8'hEC: alu_cmp(sh_x, m);
      8'hC0, 8'hC4, 8'hCC: alu_cmp(sh_y, m);
      8'h24, 8'h2C: begin
        // bit test: n and v from the operand, z from a and m
        sh_p[7:6] = m[7:6];
        sh_p[1] = ((sh_a & m) == 8'h00);
      end
      8'h8A: begin sh_a = sh_x; flag_nz(sh_a); end
      8'h98: begin sh_a = sh_y; flag_nz(sh_a); end
      8'hAA: begin sh_x = sh_a; flag_nz(sh_x); end
      8'hA8: begin sh_y = sh_a; flag_nz(sh_y); end
      8'hBA: begin sh_x = sh_sp; flag_nz(sh_x); end
      8'h9A: sh_sp = sh_x;
      8'hE8: begin sh_x = sh_x + 8'd1; flag_nz(sh_x); end
      8'hCA: begin sh_x = sh_x - 8'd1; flag_nz(sh_x); end
      8'hC8: begin sh_y = sh_y + 8'd1; flag_nz(sh_y); end
      8'h88: begin sh_y = sh_y - 8'd1; flag_nz(sh_y); end
      8'h18: sh_p[0] = 1'b0;
      8'h38: sh_p[0] = 1'b1;
      8'h58: sh_p[2] = 1'b0;
      8'h78: sh_p[2] = 1'b1;
      8'hB8: sh_p[6] = 1'b0;
      8'hD8: sh_p[3] = 1'b0;
      8'hF8: sh_p[3] = 1'b1;
      8'hEA: ;
      8'hA3, 8'hA7, 8'hAF, 8'hB3, 8'hB7, 8'hBF: begin sh_a = m; sh_x = m; flag_nz(m); end
      8'h83, 8'h87, 8'h8F, 8'h97: begin r.we = 1'b1; r.wd = sh_a & sh_x; end
      8'h03, 8'h07, 8'h0F, 8'h13, 8'h17, 8'h1B, 8'h1F: begin
        r.wd = sh_asl(m); r.we = 1'b1; sh_a = sh_a | r.wd; flag_nz(sh_a);
      end
      8'h23, 8'h27, 8'h2F, 8'h33, 8'h37, 8'h3B, 8'h3F: begin
        r.wd = sh_rol(m); r.we = 1'b1; sh_a = sh_a & r.wd; flag_nz(sh_a);
      end
      8'h43, 8'h47, 8'h4F, 8'h53, 8'h57, 8'h5B, 8'h5F: begin
        r.wd = sh_lsr(m); r.we = 1'b1; sh_a = sh_a ^ r.wd; flag_nz(sh_a);
      end
      8'h63, 8'h67, 8'h6F, 8'h73, 8'h77, 8'h7B, 8'h7F: begin
        r.wd = sh_ror(m); r.we = 1'b1; alu_adc(r.wd);
      end
      8'hC3, 8'hC7, 8'hCF, 8'hD3, 8'hD7, 8'hDB, 8'hDF: begin
        r.wd = m - 8'd1; r.we = 1'b1; alu_cmp(sh_a, r.wd);
      end
      8'hE3, 8'hE7, 8'hEF, 8'hF3, 8'hF7, 8'hFB, 8'hFF: begin
        r.wd = m + 8'd1; r.we = 1'b1; alu_adc(~r.wd);
      end
      8'h0B, 8'h2B: begin sh_a = sh_a & m; flag_nz(sh_a); sh_p[0] = sh_a[7]; end
      8'h4B: begin sh_a = sh_lsr(sh_a & m); flag_nz(sh_a); end
      8'h6B: begin
        t = sh_a & m;
        sh_a = {sh_p[0], t[7:1]};
        sh_p[0] = sh_a[6];
        sh_p[6] = sh_a[6] ^ sh_a[5];
        flag_nz(sh_a);
      end
      8'hAB: begin sh_a = sh_a & m; sh_x = sh_a; flag_nz(sh_a); end
      8'hCB: begin
        t = sh_a & sh_x;
        sh_p[0] = (t >= m);
        sh_x = t - m;
        flag_nz(sh_x);
      end
      default: r.ill = 1'b1;
    endcase
    r.a = sh_a; r.x = sh_x; r.y = sh_y; r.p = sh_p; r.sp = sh_sp;
    return r;
  endfunction

  // driver: feed pending beats, random idling, hold while paused
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready) begin
        if (pending_instr.size() > 0 && !hold_in && (calm || $urandom_range(99) >= 25)) begin
          in_valid <= 1'b1;
          {func, operand} <= pending_instr.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // predict on accepted input beats
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      expected_res.push_back(execute_instr(func, operand));
  end

  // monitor: compare accepted result beats with oldest expectation
  always @(posedge clk) begin
    exec_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_res.pop_front();
        if (write_enable !== e.we) begin
          $error("write_enable exp %0h got %0h", e.we, write_enable); errors++;
        end
        if (write_data !== e.wd) begin
          $error("write_data exp %0h got %0h", e.wd, write_data); errors++;
        end
        if (acc_out !== e.a) begin
          $error("acc_out exp %0h got %0h", e.a, acc_out); errors++;
        end
        if (x_out !== e.x) begin
          $error("x_out exp %0h got %0h", e.x, x_out); errors++;
        end
        if (y_out !== e.y) begin
          $error("y_out exp %0h got %0h", e.y, y_out); errors++;
        end
        if (status_out !== e.p) begin
          $error("status_out exp %0h got %0h", e.p, status_out); errors++;
        end
        if (sp_out !== e.sp) begin
          $error("sp_out exp %0h got %0h", e.sp, sp_out); errors++;
        end
        if (illegal !== e.ill) begin
          $error("illegal exp %0h got %0h", e.ill, illegal); errors++;
        end
      end
    end
  end

  // directed then random stimulus
  initial begin
    int k;
    logic [7:0] op;
    sh_a = 8'h00; sh_x = 8'h00; sh_y = 8'h00; sh_sp = SP_RESET; sh_p = P_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, adc overflow, sbc borrow, bit, undocumented flag rules
    pending_instr.push_back({8'hA9, 8'h00});  // lda zero
    pending_instr.push_back({8'hA9, 8'hFF});
    pending_instr.push_back({8'h69, 8'h01});  // adc wraps to zero with carry
    pending_instr.push_back({8'hA9, 8'h7F});
    pending_instr.push_back({8'h69, 8'h00});  // signed overflow with carry in
    pending_instr.push_back({8'hE9, 8'hFF});
    pending_instr.push_back({8'h24, 8'hC0});  // bit with n and v from operand
    pending_instr.push_back({8'hF8, 8'h00});  // sed, adc still binary
    pending_instr.push_back({8'h69, 8'h09});
    pending_instr.push_back({8'hA2, 8'h80});
    pending_instr.push_back({8'h9A, 8'h00});  // txs
    pending_instr.push_back({8'hBA, 8'h00});
    pending_instr.push_back({8'h6B, 8'hFF});  // arr
    pending_instr.push_back({8'h0B, 8'h80});  // anc
    pending_instr.push_back({8'hAB, 8'hF0});  // atx
    pending_instr.push_back({8'hCB, 8'hFF});  // axs borrow
    pending_instr.push_back({8'hC7, 8'h00});  // dcp on zero
    pending_instr.push_back({8'hE7, 8'hFF});  // isb on ff
    pending_instr.push_back({8'h87, 8'h00});  // sax
    pending_instr.push_back({8'h02, 8'h55});  // jam: illegal
    pending_instr.push_back({8'hEB, 8'hAA});  // illegal
    pending_instr.push_back({8'h7E, 8'h01});
    pending_instr.push_back({8'hEA, 8'h00});
    // first half random with idling
    for (k = 0; k < 250; k++) begin
      op = 8'($urandom_range(255));
      pending_instr.push_back({op, 8'($urandom_range(255))});
    end
    wait (pending_instr.size() == 0);
    // sender pause until every expected result has come
    hold_in = 1'b1;
    wait (expected_res.size() == 0 && !in_valid);
    hold_in = 1'b0;
    calm = 1'b1;
    for (k = 0; k < 100; k++)
      pending_instr.push_back({8'($urandom_range(255)), 8'($urandom_range(255))});
    wait (pending_instr.size() == 0);
    calm = 1'b0;
    for (k = 0; k < 150; k++)
      pending_instr.push_back({8'($urandom_range(255)), 8'($urandom_range(255))});
    wait (pending_instr.size() == 0);
    // last beat accepted once valid drops with nothing left to send
    wait (!in_valid);
    wait (expected_res.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS cpu6502_execute_unit_core");
    end else begin
      $display("FAIL cpu6502_execute_unit_core");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL cpu6502_execute_unit_core");
    $finish;
  end

endmodule
